### design/irqmb_pkg.sv
// Shared types and constants for the interrupt and miscellaneous register block.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package irqmb_pkg;

    // Kind of request on the input channel.
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LINE  = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CPU_COUNT = 3'd0;
    localparam logic [2:0] CFG_REVISION  = 3'd1;
    localparam logic [2:0] CFG_AAR0      = 3'd2;
    localparam logic [2:0] CFG_AAR1      = 3'd3;
    localparam logic [2:0] CFG_AAR2      = 3'd4;
    localparam logic [2:0] CFG_AAR3      = 3'd5;

    // Bus register numbers.
    localparam logic [6:0] REG_CSC  = 7'h00;
    localparam logic [6:0] REG_MISC = 7'h02;
    localparam logic [6:0] REG_AAR0 = 7'h04;
    localparam logic [6:0] REG_AAR1 = 7'h05;
    localparam logic [6:0] REG_AAR2 = 7'h06;
    localparam logic [6:0] REG_AAR3 = 7'h07;
    localparam logic [6:0] REG_DIM0 = 7'h08;
    localparam logic [6:0] REG_DIM1 = 7'h09;
    localparam logic [6:0] REG_DIM2 = 7'h18;
    localparam logic [6:0] REG_DIM3 = 7'h19;
    localparam logic [6:0] REG_DIR0 = 7'h0a;
    localparam logic [6:0] REG_DIR1 = 7'h0b;
    localparam logic [6:0] REG_DIR2 = 7'h1a;
    localparam logic [6:0] REG_DIR3 = 7'h1b;
    localparam logic [6:0] REG_DRIR = 7'h0c;

    // CSC reset value, writable bits and bits that writes never touch.
    localparam logic [63:0] CSC_RESET = 64'h0000_0000_0000_4003;
    localparam logic [63:0] CSC_WMASK = 64'h0777_777f_ff3f_0000;
    localparam logic [63:0] CSC_KEEP  = 64'h0000_0000_0000_ffff;

    // MISC bits that a write may carry without being flagged.
    localparam logic [63:0] MISC_DECODED = 64'h0000_0fff_11ff_fff0;

    // MISC field positions.
    localparam int MISC_TIMER_LSB = 4;
    localparam int MISC_IPCLR_LSB = 8;
    localparam int MISC_IPREQ_LSB = 12;
    localparam int MISC_ARB_CLR   = 24;

    // Pending bits feeding the high and low device lines.
    localparam int HIGH_DEV_SHIFT = 58;
    localparam int LOW_DEV_TOP    = 55;

    // Per-CPU line bit positions.
    localparam int IRQ_HIGH_DEV = 0;
    localparam int IRQ_LOW_DEV  = 1;
    localparam int IRQ_TIMER    = 2;
    localparam int IRQ_IPI      = 3;

    // One request as held in the input register.
    typedef struct packed {
        action_t     action;
        logic [6:0]  reg_index;
        logic        upper_half;
        logic [31:0] write_data;
        logic [5:0]  irq_line;
        logic        irq_level;
    } req_t;

    // One result as held in the output register.
    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] cpu_irq_lines;
        logic        unhandled;
    } rsp_t;

endpackage

### design/irqmb_regfile.sv
// Architectural state and update logic of the interrupt register block.
// Depends on irqmb_pkg for request/result types and register constants.
`timescale 1ns / 1ps

module irqmb_regfile #(
    parameter int NUM_CPUS  = 4,
    parameter int IRQ_LINES = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [63:0]    cfg_wr_data,
    input  logic           fire,
    input  irqmb_pkg::req_t req,
    output irqmb_pkg::rsp_t rsp
);
    import irqmb_pkg::*;

    // Configuration registers.
    logic [2:0]  cpu_count_reg;
    logic [7:0]  revision_reg;
    logic [63:0] aar_reg [4];

    // Architectural state.
    logic [63:0]          csc_reg, csc_next;
    logic [3:0]           won_reg, won_next;
    logic [3:0]           try_reg, try_next;
    logic [31:0]          held_reg, held_next;
    logic [IRQ_LINES-1:0] raw_reg, raw_next;
    logic [3:0]           bits_reg [NUM_CPUS];
    logic [3:0]           bits_next [NUM_CPUS];
    logic [63:0]          mask_reg [NUM_CPUS];
    logic [63:0]          mask_next [NUM_CPUS];
    logic [IRQ_LINES-1:0] pend_reg [NUM_CPUS];
    logic [IRQ_LINES-1:0] pend_next [NUM_CPUS];

    // Decode helpers.
    logic [1:0]           cpu_slot;
    logic [63:0]          wr_val;
    logic [63:0]          reg_val;
    logic                 reg_bad;
    logic [IRQ_LINES-1:0] line_onehot;
    logic                 line_ok;
    logic                 misc_commit;

    assign cpu_slot    = {req.reg_index[4], req.reg_index[0]};
    assign wr_val      = {req.write_data, held_reg};
    assign line_onehot = IRQ_LINES'(64'd1 << req.irq_line);
    assign line_ok     = {1'b0, req.irq_line} < 7'(IRQ_LINES);
    assign misc_commit = fire && req.action == ACT_WRITE && req.upper_half
                         && req.reg_index == REG_MISC;

    // Read decode of the addressed 64-bit register.
    always_comb begin
        reg_val = '0;
        reg_bad = 1'b0;
        unique case (req.reg_index)
            REG_CSC: reg_val = csc_reg;
            REG_MISC: begin
                reg_val[39:32] = revision_reg;
                reg_val[23:20] = try_reg;
                reg_val[19:16] = won_reg;
                for (int i = 0; i < NUM_CPUS; i++) begin
                    reg_val[MISC_TIMER_LSB + i] = bits_reg[i][IRQ_TIMER];
                    reg_val[MISC_IPCLR_LSB + i] = bits_reg[i][IRQ_IPI];
                end
            end
            REG_AAR0: reg_val = aar_reg[0];
            REG_AAR1: reg_val = aar_reg[1];
            REG_AAR2: reg_val = aar_reg[2];
            REG_AAR3: reg_val = aar_reg[3];
            REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: begin
                reg_bad = 1'b1;
                for (int i = 0; i < NUM_CPUS; i++) begin
                    if (cpu_slot == 2'(i)) begin
                        reg_val = mask_reg[i];
                        reg_bad = 1'b0;
                    end
                end
            end
            REG_DIR0, REG_DIR1, REG_DIR2, REG_DIR3: begin
                reg_bad = 1'b1;
                for (int i = 0; i < NUM_CPUS; i++) begin
                    if (cpu_slot == 2'(i)) begin
                        reg_val = 64'(pend_reg[i]);
                        reg_bad = 1'b0;
                    end
                end
            end
            REG_DRIR: reg_val = 64'(raw_reg);
            default: reg_bad = 1'b1;
        endcase
    end

    // Next state and result for the request in the input register.
    always_comb begin
        logic                 recompute;
        logic [3:0]           won_tmp;
        logic [3:0]           try_tmp;
        logic [IRQ_LINES-1:0] pend_tmp;
        logic [63:0]          pend_wide;

        recompute  = 1'b0;
        won_tmp    = won_reg;
        try_tmp    = try_reg;
        pend_tmp   = '0;
        pend_wide  = '0;
        csc_next   = csc_reg;
        won_next   = won_reg;
        try_next   = try_reg;
        held_next  = held_reg;
        raw_next   = raw_reg;
        bits_next  = bits_reg;
        mask_next  = mask_reg;
        pend_next  = pend_reg;
        rsp        = '0;

        if (fire) begin
            unique case (req.action)
                ACT_READ: begin
                    if (req.upper_half) begin
                        rsp.read_data = held_reg;
                    end else begin
                        rsp.read_data = reg_val[31:0];
                        rsp.unhandled = reg_bad;
                        held_next     = reg_val[63:32];
                    end
                end
                ACT_WRITE: begin
                    if (!req.upper_half) begin
                        held_next = req.write_data;
                    end else begin
                        unique case (req.reg_index)
                            REG_CSC: csc_next = (csc_reg & CSC_KEEP) | (wr_val & CSC_WMASK);
                            REG_MISC: begin
                                if (wr_val[MISC_ARB_CLR]) begin
                                    won_tmp = '0;
                                    try_tmp = '0;
                                end
                                for (int i = 0; i < NUM_CPUS; i++) begin
                                    if (cpu_count_reg > 3'(i)) begin
                                        if (wr_val[MISC_TIMER_LSB + i])
                                            bits_next[i][IRQ_TIMER] = 1'b0;
                                        if (wr_val[MISC_IPCLR_LSB + i])
                                            bits_next[i][IRQ_IPI] = 1'b0;
                                        if (wr_val[MISC_IPREQ_LSB + i])
                                            bits_next[i][IRQ_IPI] = 1'b1;
                                    end
                                end
                                // First writer wins: load only while the field is clear.
                                won_next = (|wr_val[19:16] && won_tmp == '0)
                                           ? wr_val[19:16] : won_tmp;
                                try_next = (|wr_val[23:20] && try_tmp == '0)
                                           ? wr_val[23:20] : try_tmp;
                                rsp.unhandled = |(wr_val & ~MISC_DECODED);
                            end
                            REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: begin
                                rsp.unhandled = 1'b1;
                                for (int i = 0; i < NUM_CPUS; i++) begin
                                    if (cpu_slot == 2'(i)) begin
                                        mask_next[i]  = wr_val;
                                        rsp.unhandled = 1'b0;
                                        recompute     = 1'b1;
                                    end
                                end
                            end
                            default: rsp.unhandled = 1'b1;
                        endcase
                    end
                end
                ACT_LINE: begin
                    if (line_ok) begin
                        raw_next  = req.irq_level ? (raw_reg | line_onehot)
                                                  : (raw_reg & ~line_onehot);
                        recompute = 1'b1;
                    end
                end
                ACT_TICK: begin
                    for (int i = 0; i < NUM_CPUS; i++) begin
                        if (cpu_count_reg > 3'(i))
                            bits_next[i][IRQ_TIMER] = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // Refresh pending words and device lines of the present CPUs.
        if (recompute) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                if (cpu_count_reg > 3'(i)) begin
                    pend_tmp                   = raw_next & mask_next[i][IRQ_LINES-1:0];
                    pend_wide                  = 64'(pend_tmp);
                    pend_next[i]               = pend_tmp;
                    bits_next[i][IRQ_HIGH_DEV] = |pend_wide[63:HIGH_DEV_SHIFT];
                    bits_next[i][IRQ_LOW_DEV]  = |pend_wide[LOW_DEV_TOP:0];
                end
            end
        end

        for (int i = 0; i < NUM_CPUS; i++) begin
            rsp.cpu_irq_lines[4*i +: 4] = bits_next[i];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_count_reg <= 3'd1;
            revision_reg  <= 8'd8;
            for (int i = 0; i < 4; i++) aar_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CPU_COUNT: cpu_count_reg <= cfg_wr_data[2:0];
                CFG_REVISION:  revision_reg  <= cfg_wr_data[7:0];
                CFG_AAR0:      aar_reg[0]    <= cfg_wr_data;
                CFG_AAR1:      aar_reg[1]    <= cfg_wr_data;
                CFG_AAR2:      aar_reg[2]    <= cfg_wr_data;
                CFG_AAR3:      aar_reg[3]    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csc_reg  <= CSC_RESET;
            won_reg  <= '0;
            try_reg  <= '0;
            held_reg <= '0;
            raw_reg  <= '0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                bits_reg[i] <= '0;
                mask_reg[i] <= '0;
                pend_reg[i] <= '0;
            end
        end else begin
            csc_reg   <= csc_next;
            won_reg   <= won_next;
            try_reg   <= try_next;
            held_reg  <= held_next;
            raw_reg   <= raw_next;
            bits_reg  <= bits_next;
            mask_reg  <= mask_next;
            pend_reg  <= pend_next;
        end
    end

    // A claimed arbitration field changes only through a MISC write.
    a_won_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (won_reg != '0 && !misc_commit) |=> $stable(won_reg))
        else $error("arbitration won field changed without a MISC write");

    // Only bus reads return data.
    a_read_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && req.action != ACT_READ) |-> rsp.read_data == '0)
        else $error("read data nonzero on a non-read request");

    // A tick with CPU zero present leaves its timer bit set.
    a_tick_sets_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && req.action == ACT_TICK && cpu_count_reg != '0)
        |=> bits_reg[0][IRQ_TIMER])
        else $error("timer tick did not set the timer bit");

    // Device line events never flag an unhandled access.
    a_event_handled: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (req.action == ACT_LINE || req.action == ACT_TICK)) |-> !rsp.unhandled)
        else $error("unhandled flag raised on an interrupt event");

endmodule

### design/interrupt_and_misc_register_block_core.sv
// Top level of the interrupt and miscellaneous register block: handshake stages.
// Depends on irqmb_pkg and irqmb_regfile.
`timescale 1ns / 1ps

// Each request (bus half-word read or write, device line change or timer
// tick) passes an input register, is resolved against the register state,
// and lands in an output register. One request is accepted per clock while
// the block is not stalled; a request moves on to the output register when
// that register is free or drains. The input register can take one request
// while a finished result waits for m_ready, and the block stalls only when
// both registers are full and m_ready is low. Configuration writes take
// effect at the clock edge where cfg_wr_en is high.
module interrupt_and_misc_register_block_core #(
    parameter int NUM_CPUS  = 4,
    parameter int IRQ_LINES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [6:0]  s_reg_index,
    input  logic        s_upper_half,
    input  logic [31:0] s_write_data,
    input  logic [5:0]  s_irq_line,
    input  logic        s_irq_level,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic [15:0] m_cpu_irq_lines,
    output logic        m_unhandled
);
    import irqmb_pkg::*;

    req_t req_reg;
    rsp_t rsp_reg;
    rsp_t rsp_comb;
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic s_fire;
    logic fire;

    // Handshake: the stage moves when the output register is free or drains.
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_fire ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.action     <= action_t'(s_action);
            req_reg.reg_index  <= s_reg_index;
            req_reg.upper_half <= s_upper_half;
            req_reg.write_data <= s_write_data;
            req_reg.irq_line   <= s_irq_line;
            req_reg.irq_level  <= s_irq_level;
        end
        if (fire) begin
            rsp_reg <= rsp_comb;
        end
    end

    // Register state and request decode.
    irqmb_regfile #(
        .NUM_CPUS  (NUM_CPUS),
        .IRQ_LINES (IRQ_LINES)
    ) u_regfile (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .req         (req_reg),
        .rsp         (rsp_comb)
    );

    assign m_valid         = out_valid_reg;
    assign m_read_data     = rsp_reg.read_data;
    assign m_cpu_irq_lines = rsp_reg.cpu_irq_lines;
    assign m_unhandled     = rsp_reg.unhandled;

    // A request waiting in the input register is not dropped while stalled.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("input request lost while output stalled");

    // A new result only follows a request that left the input register.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without a pending request");

    // With both registers full the block refuses new requests.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("request accepted with both stages full");

endmodule

### tb/interrupt_and_misc_register_block_core_tb.sv
// Self-checking testbench for the interrupt and miscellaneous register block.
// Predicts every result in-line and scoreboards the result channel; needs only
// irqmb_pkg, irqmb_regfile and the interrupt_and_misc_register_block_core RTL.
`timescale 1ns / 1ps

module interrupt_and_misc_register_block_core_tb;

    import irqmb_pkg::*;

    localparam int LONG_STALL_CYCLES = 120;
    localparam int PHASE_COUNT       = 8;
    localparam int PHASE_ITEMS       = 165;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_index   = CFG_CPU_COUNT;
    logic [63:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    req_t        drv_req = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic [15:0] m_cpu_irq_lines;
    logic        m_unhandled;

    // Stimulus and scoreboard storage.
    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    logic req_taken = 1'b0;
    int   mismatches = 0;

    // Flow control knobs shared by the initial block and the driving processes.
    int   idle_pct = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    logic long_stall_go = 1'b0;
    logic long_stall_done = 1'b0;

    // Predicted configuration.
    logic [2:0]  cpu_count_cfg;
    logic [7:0]  revision_cfg;
    logic [63:0] aar_cfg [4];

    // Predicted register state.
    logic [63:0] csc_word;
    logic [3:0]  arb_won;
    logic [3:0]  arb_try;
    logic [3:0]  cpu_bits [4];
    logic [63:0] dim_word [4];
    logic [63:0] dir_word [4];
    logic [63:0] drir_word;
    logic [31:0] held_word;

    interrupt_and_misc_register_block_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (drv_req.action),
        .s_reg_index     (drv_req.reg_index),
        .s_upper_half    (drv_req.upper_half),
        .s_write_data    (drv_req.write_data),
        .s_irq_line      (drv_req.irq_line),
        .s_irq_level     (drv_req.irq_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_cpu_irq_lines (m_cpu_irq_lines),
        .m_unhandled     (m_unhandled)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // CPU count saturates at four; zero means no CPU takes interrupt updates.
    function automatic int live_cpus();
        return (cpu_count_cfg > 3'd4) ? 4 : int'(cpu_count_cfg);
    endfunction

    // Rebuild each present CPU's pending word and its two device lines.
    function automatic void refresh_device_lines();
        logic [63:0] hits;
        for (int i = 0; i < live_cpus(); i++) begin
            hits = drir_word & dim_word[i];
            dir_word[i] = hits;
            cpu_bits[i][IRQ_HIGH_DEV] = |hits[63:HIGH_DEV_SHIFT];
            cpu_bits[i][IRQ_LOW_DEV]  = |hits[LOW_DEV_TOP:0];
        end
    endfunction

    // Apply one request to the predicted state and return the result it yields.
    function automatic rsp_t resolve_request(req_t r);
        rsp_t        res;
        logic [63:0] word;
        logic [1:0]  slot;
        res  = '0;
        word = '0;
        slot = {r.reg_index[4], r.reg_index[0]};
        case (r.action)
            ACT_READ: begin
                if (r.upper_half) begin
                    res.read_data = held_word;
                end else begin
                    case (r.reg_index)
                        REG_CSC: word = csc_word;
                        REG_MISC: begin
                            word[39:32] = revision_cfg;
                            word[23:20] = arb_try;
                            word[19:16] = arb_won;
                            for (int i = 0; i < 4; i++) begin
                                word[MISC_TIMER_LSB + i] = cpu_bits[i][IRQ_TIMER];
                                word[MISC_IPCLR_LSB + i] = cpu_bits[i][IRQ_IPI];
                            end
                        end
                        REG_AAR0, REG_AAR1, REG_AAR2, REG_AAR3:
                            word = aar_cfg[r.reg_index[1:0]];
                        REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: word = dim_word[slot];
                        REG_DIR0, REG_DIR1, REG_DIR2, REG_DIR3: word = dir_word[slot];
                        REG_DRIR: word = drir_word;
                        default: res.unhandled = 1'b1;
                    endcase
                    held_word     = word[63:32];
                    res.read_data = word[31:0];
                end
            end
            ACT_WRITE: begin
                if (!r.upper_half) begin
                    held_word = r.write_data;
                end else begin
                    word = {r.write_data, held_word};
                    case (r.reg_index)
                        REG_CSC: csc_word = (csc_word & CSC_KEEP) | (word & CSC_WMASK);
                        REG_MISC: begin
                            if (word[MISC_ARB_CLR]) begin
                                arb_try = '0;
                                arb_won = '0;
                            end
                            for (int i = 0; i < live_cpus(); i++) begin
                                if (word[MISC_TIMER_LSB + i]) cpu_bits[i][IRQ_TIMER] = 1'b0;
                                if (word[MISC_IPCLR_LSB + i]) cpu_bits[i][IRQ_IPI] = 1'b0;
                                if (word[MISC_IPREQ_LSB + i]) cpu_bits[i][IRQ_IPI] = 1'b1;
                            end
                            // First writer wins: the fields load only while clear.
                            if (word[19:16] != 4'd0 && arb_won == 4'd0) arb_won = word[19:16];
                            if (word[23:20] != 4'd0 && arb_try == 4'd0) arb_try = word[23:20];
                            res.unhandled = |(word & ~MISC_DECODED);
                        end
                        REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: begin
                            dim_word[slot] = word;
                            refresh_device_lines();
                        end
                        default: res.unhandled = 1'b1;
                    endcase
                end
            end
            ACT_LINE: begin
                drir_word[r.irq_line] = r.irq_level;
                refresh_device_lines();
            end
            default: begin
                for (int i = 0; i < live_cpus(); i++) cpu_bits[i][IRQ_TIMER] = 1'b1;
            end
        endcase
        res.cpu_irq_lines = {cpu_bits[3], cpu_bits[2], cpu_bits[1], cpu_bits[0]};
        return res;
    endfunction

    // Check accepted results against the oldest prediction, then predict for
    // the request accepted at this edge.
    always @(posedge aclk) begin
        rsp_t got;
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            got.read_data     = m_read_data;
            got.cpu_irq_lines = m_cpu_irq_lines;
            got.unhandled     = m_unhandled;
            if (expected_rsps.size() == 0) begin
                $display("%0t: result with none expected: read_data %h lines %h unhandled %b",
                         $time, got.read_data, got.cpu_irq_lines, got.unhandled);
                mismatches++;
            end else begin
                want = expected_rsps.pop_front();
                if (got.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h, got %h",
                             $time, want.read_data, got.read_data);
                    mismatches++;
                end
                if (got.cpu_irq_lines !== want.cpu_irq_lines) begin
                    $display("%0t: cpu_irq_lines expected %h, got %h",
                             $time, want.cpu_irq_lines, got.cpu_irq_lines);
                    mismatches++;
                end
                if (got.unhandled !== want.unhandled) begin
                    $display("%0t: unhandled expected %b, got %b",
                             $time, want.unhandled, got.unhandled);
                    mismatches++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) expected_rsps.push_back(resolve_request(drv_req));
        req_taken <= aresetn && s_valid && s_ready;
    end

    // Request driver: holds each request until taken, with random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // The current request is still waiting for s_ready.
        end else if (send_gap > 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_reqs.size() == 0) begin
            s_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid  <= 1'b0;
            send_gap <= $urandom_range(0, 17);
        end else begin
            s_valid <= 1'b1;
            drv_req <= pending_reqs.pop_front();
        end
    end

    // Result side back-pressure, including one long hold-off on request.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (long_stall_go && !long_stall_done) begin
            m_ready         <= 1'b0;
            stall_left      <= LONG_STALL_CYCLES;
            long_stall_done <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic req_t random_request();
        req_t r;
        r.action     = action_t'($urandom_range(0, 3));
        r.reg_index  = 7'($urandom);
        r.upper_half = 1'($urandom);
        r.write_data = $urandom;
        r.irq_line   = 6'($urandom);
        r.irq_level  = 1'($urandom);
        return r;
    endfunction

    // Writable targets come first so a write can draw from the low part only.
    function automatic logic [6:0] pick_register(bit for_write);
        case ($urandom_range(0, for_write ? 5 : 14))
            0:  return REG_CSC;
            1:  return REG_MISC;
            2:  return REG_DIM0;
            3:  return REG_DIM1;
            4:  return REG_DIM2;
            5:  return REG_DIM3;
            6:  return REG_AAR0;
            7:  return REG_AAR1;
            8:  return REG_AAR2;
            9:  return REG_AAR3;
            10: return REG_DIR0;
            11: return REG_DIR1;
            12: return REG_DIR2;
            13: return REG_DIR3;
            default: return REG_DRIR;
        endcase
    endfunction

    task automatic push_req(action_t act, logic [6:0] regnum, bit upper,
                            logic [31:0] data, logic [5:0] line, bit level);
        req_t r;
        r.action     = act;
        r.reg_index  = regnum;
        r.upper_half = upper;
        r.write_data = data;
        r.irq_line   = line;
        r.irq_level  = level;
        pending_reqs.push_back(r);
    endtask

    // Mostly complete half-word pairs and interrupt events, some raw noise.
    task automatic queue_random_items(int count);
        req_t        r;
        logic [63:0] word;
        int          roll;
        int          left;
        left = count;
        while (left > 0) begin
            r    = random_request();
            roll = $urandom_range(0, 19);
            if (roll < 12) begin
                r.reg_index = pick_register(roll < 6);
                word = {$urandom, $urandom};
                if (roll < 6) begin
                    r.action = ACT_WRITE;
                    if (r.reg_index == REG_MISC && $urandom_range(0, 3) != 0) begin
                        word &= MISC_DECODED;
                    end else if (r.reg_index[3]) begin
                        // Only the DIM registers have bit 3 among the write targets.
                        case ($urandom_range(0, 4))
                            0: word = '0;
                            1: word = '1;
                            2: word &= 64'hfc00_0000_0000_0000;
                            default: ;
                        endcase
                    end
                end else begin
                    r.action = ACT_READ;
                end
                r.upper_half = 1'b0;
                r.write_data = word[31:0];
                pending_reqs.push_back(r);
                r.upper_half = 1'b1;
                r.write_data = word[63:32];
                r.irq_line   = 6'($urandom);
                pending_reqs.push_back(r);
                left -= 2;
            end else begin
                if (roll < 17) r.action = ACT_LINE;
                else if (roll == 17) r.action = ACT_TICK;
                pending_reqs.push_back(r);
                left -= 1;
            end
        end
    endtask

    task automatic wait_for_drain();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0);
    endtask

    // Configuration writes happen only while the block is idle.
    task automatic write_cfg(logic [2:0] idx, logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_CPU_COUNT: cpu_count_cfg = value[2:0];
            CFG_REVISION:  revision_cfg  = value[7:0];
            default:       aar_cfg[2'(idx - CFG_AAR0)] = value;
        endcase
    endtask

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [2:0] cpus;
        // Predicted state after reset.
        cpu_count_cfg = 3'd1;
        revision_cfg  = 8'd8;
        csc_word      = CSC_RESET;
        arb_won       = '0;
        arb_try       = '0;
        drir_word     = '0;
        held_word     = '0;
        for (int i = 0; i < 4; i++) begin
            aar_cfg[i]  = '0;
            cpu_bits[i] = '0;
            dim_word[i] = '0;
            dir_word[i] = '0;
        end

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset configuration.
        idle_pct = 10;
        push_req(ACT_READ,  REG_CSC,  1'b1, 32'h0,        6'd0,  1'b0);  // high half first
        push_req(ACT_READ,  REG_CSC,  1'b0, 32'hffffffff, 6'd63, 1'b1);
        push_req(ACT_READ,  REG_CSC,  1'b1, 32'h0,        6'd0,  1'b0);
        push_req(ACT_WRITE, REG_CSC,  1'b0, 32'hffffffff, 6'd0,  1'b0);
        push_req(ACT_READ,  REG_CSC,  1'b1, 32'h0,        6'd0,  1'b0);  // returns held write
        push_req(ACT_WRITE, REG_CSC,  1'b0, 32'hffffffff, 6'd0,  1'b0);
        push_req(ACT_WRITE, REG_CSC,  1'b1, 32'hffffffff, 6'd0,  1'b0);
        push_req(ACT_READ,  REG_CSC,  1'b0, 32'h0,        6'd0,  1'b0);
        push_req(ACT_READ,  REG_CSC,  1'b1, 32'h0,        6'd0,  1'b0);
        push_req(ACT_WRITE, REG_MISC, 1'b0, 32'hffffffff, 6'd0,  1'b0);
        push_req(ACT_WRITE, REG_MISC, 1'b1, 32'hffffffff, 6'd0,  1'b0);
        push_req(ACT_READ,  REG_MISC, 1'b0, 32'h0,        6'd0,  1'b0);
        push_req(ACT_READ,  REG_MISC, 1'b1, 32'h0,        6'd0,  1'b0);
        push_req(ACT_READ,  7'h7f,    1'b0, 32'h0,        6'd0,  1'b0);  // undecoded register
        push_req(ACT_READ,  7'h7f,    1'b1, 32'h0,        6'd0,  1'b0);
        push_req(ACT_WRITE, REG_AAR0, 1'b0, 32'h0,        6'd0,  1'b0);
        push_req(ACT_WRITE, REG_AAR0, 1'b1, 32'h0,        6'd0,  1'b0);  // read-only to bus
        push_req(ACT_TICK,  REG_CSC,  1'b0, 32'h0,        6'd0,  1'b0);
        push_req(ACT_WRITE, REG_DIM0, 1'b0, 32'hffffffff, 6'd0,  1'b0);
        push_req(ACT_WRITE, REG_DIM0, 1'b1, 32'hffffffff, 6'd0,  1'b0);
        push_req(ACT_LINE,  REG_CSC,  1'b0, 32'h0,        6'd63, 1'b1);
        push_req(ACT_LINE,  REG_CSC,  1'b0, 32'h0,        6'd0,  1'b1);
        push_req(ACT_READ,  REG_DIR0, 1'b0, 32'h0,        6'd0,  1'b0);
        push_req(ACT_LINE,  REG_CSC,  1'b0, 32'h0,        6'd63, 1'b0);
        push_req(ACT_WRITE, REG_DRIR, 1'b1, 32'h0,        6'd0,  1'b0);
        push_req(ACT_WRITE, REG_DIR0, 1'b1, 32'h0,        6'd0,  1'b0);
        wait_for_drain();

        // Random phases, each under its own configuration.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       cpus = 3'd4;
                1:       cpus = 3'd0;
                2:       cpus = 3'd7;
                3:       cpus = 3'd2;
                4:       cpus = 3'd3;
                5:       cpus = 3'd1;
                default: cpus = 3'($urandom_range(1, 4));
            endcase
            write_cfg(CFG_CPU_COUNT, {61'd0, cpus});
            write_cfg(CFG_REVISION, (p == 0) ? 64'd255 : (p == 1) ? 64'd0 : 64'($urandom));
            for (int k = 0; k < 4; k++) begin
                write_cfg(CFG_AAR0 + 3'(k),
                          (p == 0) ? '1 : (p == 1) ? '0 : {$urandom, $urandom});
            end
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            @(posedge aclk);
            idle_pct = (p == 4 || p == PHASE_COUNT - 1) ? 0 : $urandom_range(5, 30);
            if (p == 2) long_stall_go = 1'b1;
            queue_random_items(PHASE_ITEMS);
            wait_for_drain();
        end

        repeat (10) @(negedge aclk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
